### hdl/b64d_pkg.sv
// Shared types, constants and the character decode function for the base64 stream decoder.
`default_nettype none

package b64d_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned GROUP_N  = 4;
    localparam int unsigned STORE_W  = SEXTET_W * (GROUP_N - 1);
    localparam int unsigned WORD_W   = SEXTET_W * GROUP_N;
    localparam int unsigned POS_W    = $clog2(GROUP_N);
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BURST_N  = WORD_W / BYTE_W;
    localparam int unsigned PEND_W   = $clog2(BURST_N + 1);

    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(GROUP_N - 1);
    localparam logic [PEND_W-1:0] PEND_BURST = PEND_W'(BURST_N);
    localparam logic [PEND_W-1:0] PEND_ONE   = PEND_W'(1);

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_present;
        logic              end_of_message;
        logic              too_short;
    } out_item_t;

    typedef struct packed {
        logic                hit;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    // Alphabet lookup; '=' maps to zero, anything outside the alphabet misses.
    function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
        sextet_t           s;
        logic [CHAR_W-1:0] d;
        s = '{hit: 1'b0, value: '0};
        d = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            s = '{hit: 1'b1, value: d[SEXTET_W-1:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            s = '{hit: 1'b1, value: d[SEXTET_W-1:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            s = '{hit: 1'b1, value: d[SEXTET_W-1:0]};
        end else if (c == 8'h2B) begin
            s = '{hit: 1'b1, value: 6'd62};
        end else if (c == 8'h2F) begin
            s = '{hit: 1'b1, value: 6'd63};
        end else if (c == 8'h3D) begin
            s = '{hit: 1'b1, value: 6'd0};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/b64d_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface b64d_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/base64_stream_decoder.sv
// Base64 stream decoder: one character in per transaction, decoded bytes out one per transaction.
// A character is registered in the input stage, and the results it causes in the result stage.
// Throughput: one character per cycle unless stalled; a completed group drains its 3 bytes one
//   per output handshake; a result-causing character arriving meanwhile waits in the input stage.
// Reset (rst_n low, asynchronous): both stages empty, group position, sextet store and
//   the full-group flag cleared. Each message-final character also clears the group state.
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    b64d_stream_if.sink   char_stream,
    b64d_stream_if.source byte_stream
);

    // ------------------------------------------------------------------
    // Input stage: one registered character transaction.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // Group state carried across characters.
    logic [POS_W-1:0]   group_pos_reg,  group_pos_next;
    logic [STORE_W-1:0] store_reg,      store_next;
    logic               seen_full_reg,  seen_full_next;

    // Result stage: up to three pending results, shifted out MSB byte first.
    logic [PEND_W-1:0]  pend_reg,    pend_next;
    logic [WORD_W-1:0]  word_reg,    word_next;
    logic               present_reg, present_next;
    logic               eom_reg,     eom_next;
    logic               short_reg,   short_next;

    sextet_t sx;
    logic    complete;     // this character closes a group of four
    logic    produces;     // this character causes at least one result
    logic    out_fire;
    logic    burst_free;   // result stage can take a new burst this cycle
    logic    advance;      // input-stage character is processed this cycle
    logic    in_fire;

    assign sx       = sextet_of(in_char_reg);
    assign complete = sx.hit && (group_pos_reg == POS_LAST);
    assign produces = complete || in_last_reg;

    assign out_fire   = byte_stream.valid && byte_stream.ready;
    assign burst_free = (pend_reg == '0) || ((pend_reg == PEND_ONE) && out_fire);
    assign advance    = in_valid_reg && (!produces || burst_free);

    assign char_stream.ready = !in_valid_reg || advance;
    assign in_fire           = char_stream.valid && char_stream.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            in_char_reg <= char_stream.payload.in_char;
            in_last_reg <= char_stream.payload.last_char;
        end
    end

    // ------------------------------------------------------------------
    // Group state update. A message-final character always returns the
    // group to empty; a completed group marks the message as long enough.
    // ------------------------------------------------------------------
    always_comb begin
        group_pos_next = group_pos_reg;
        store_next     = store_reg;
        seen_full_next = seen_full_reg;
        if (advance) begin
            if (in_last_reg) begin
                group_pos_next = '0;
                store_next     = '0;
                seen_full_next = 1'b0;
            end else if (complete) begin
                group_pos_next = '0;
                store_next     = '0;
                seen_full_next = 1'b1;
            end else if (sx.hit) begin
                group_pos_next = group_pos_reg + POS_W'(1);
                store_next     = {store_reg[STORE_W-SEXTET_W-1:0], sx.value};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            group_pos_reg <= '0;
            store_reg     <= '0;
            seen_full_reg <= 1'b0;
        end else begin
            group_pos_reg <= group_pos_next;
            store_reg     <= store_next;
            seen_full_reg <= seen_full_next;
        end
    end

    // ------------------------------------------------------------------
    // Result stage. A completed group loads three bytes; otherwise a final
    // character loads one bare end marker (too short if no group was seen).
    // End of message rides on the last pending result only.
    // ------------------------------------------------------------------
    always_comb begin
        pend_next    = pend_reg;
        word_next    = word_reg;
        present_next = present_reg;
        eom_next     = eom_reg;
        short_next   = short_reg;
        if (advance && produces) begin
            if (complete) begin
                pend_next    = PEND_BURST;
                word_next    = {store_reg, sx.value};
                present_next = 1'b1;
                eom_next     = in_last_reg;
                short_next   = 1'b0;
            end else begin
                pend_next    = PEND_ONE;
                word_next    = '0;
                present_next = 1'b0;
                eom_next     = 1'b1;
                short_next   = !seen_full_reg;
            end
        end else if (out_fire) begin
            pend_next = pend_reg - PEND_ONE;
            word_next = {word_reg[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk) begin
        word_reg    <= word_next;
        present_reg <= present_next;
        eom_reg     <= eom_next;
        short_reg   <= short_next;
    end

    assign byte_stream.valid                  = (pend_reg != '0);
    assign byte_stream.payload.out_byte       = present_reg ?
                                                word_reg[WORD_W-1 -: BYTE_W] : '0;
    assign byte_stream.payload.byte_present   = present_reg;
    assign byte_stream.payload.end_of_message = eom_reg && (pend_reg == PEND_ONE);
    assign byte_stream.payload.too_short      = short_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_marker_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stream.valid && !byte_stream.payload.byte_present
            |-> byte_stream.payload.end_of_message)
        else $error("bare end marker without end of message");

    a_short_only_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stream.valid && byte_stream.payload.too_short
            |-> !byte_stream.payload.byte_present)
        else $error("too_short flagged on a data byte");

    a_group_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (complete || in_last_reg) |=> (group_pos_reg == '0))
        else $error("group position not cleared after group close");

    a_no_burst_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && produces |-> burst_free)
        else $error("new results loaded over pending results");

endmodule

`default_nettype wire

### test/tb_base64_stream_decoder.sv
// Self-checking testbench for base64_stream_decoder: directed table, random messages, scoreboard.
`default_nettype none

module tb_base64_stream_decoder
    import b64d_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Per-item idle draw for both channels.
    localparam int unsigned MAX_GAP        = 16;
    // Characters wanted from the random part, noise included; the directed table adds the rest.
    localparam int unsigned RANDOM_ITEMS   = 100;
    // No transaction on either side for this many cycles means the block is hung.
    // The slowest legal stretch is a longest sender gap plus the passage through the input and result
    // stages, or a longest receiver stall; the limit is taken well over that.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected result, past the longest receiver stall,
    // so a stray extra result still gets taken and flagged.
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned DIRECTED_N     = 23;

    // Bare end markers, the only results that the directed table types in.
    localparam out_item_t END_TOO_SHORT = '{out_byte: 8'h00, byte_present: 1'b0,
                                            end_of_message: 1'b1, too_short: 1'b1};
    localparam out_item_t END_AFTER_GROUP = '{out_byte: 8'h00, byte_present: 1'b0,
                                              end_of_message: 1'b1, too_short: 1'b0};

    // One row of stimulus. A marked row carries its own single expected result;
    // every other row is checked against the decode model below.
    typedef struct packed {
        in_item_t  item;
        logic      marked;
        out_item_t want;
    } char_row_t;

    logic clk = 1'b0;
    logic rst_n;

    b64d_stream_if #(.payload_t(in_item_t))  char_if ();
    b64d_stream_if #(.payload_t(out_item_t)) byte_if ();

    base64_stream_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .byte_stream (byte_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    char_row_t   char_rows [$];      // everything the sender will present, in order
    out_item_t   pending_bytes [$];  // decoded results still owed by the block
    char_row_t   directed_rows [DIRECTED_N];
    int unsigned chars_taken;
    int unsigned errors;
    int unsigned stalled_cycles;
    bit          steady;             // set during stretches where neither side idles

    // Decode model state: sextets of the open group, oldest in the high bits.
    logic [1:0]  group_pos;
    logic [17:0] held_sextets;
    logic        had_group;
    out_item_t   fresh [3];
    int unsigned fresh_n;

    // Returns {hit, sextet}; hit is low for anything outside the alphabet.
    function automatic logic [6:0] alphabet_lookup(logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
        if (c == "+")             return {1'b1, 6'd62};
        if (c == "/")             return {1'b1, 6'd63};
        if (c == "=")             return {1'b1, 6'd0};
        return 7'd0;
    endfunction

    // Index 0..63 gives the alphabet in sextet order, 64 gives the pad.
    function automatic logic [7:0] alphabet_char(int unsigned k);
        if (k < 26) return 8'("A" + k);
        if (k < 52) return 8'("a" + k - 26);
        if (k < 62) return 8'("0" + k - 52);
        if (k == 62) return "+";
        if (k == 63) return "/";
        return "=";
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        logic [6:0] hv;
        c  = 8'($urandom_range(0, 255));
        hv = alphabet_lookup(c);
        while (hv[6])
        begin
            c  = 8'($urandom_range(0, 255));
            hv = alphabet_lookup(c);
        end
        return c;
    endfunction

    function automatic char_row_t plain_row(logic [7:0] c, logic last);
        char_row_t r;
        r.item   = '{in_char: c, last_char: last};
        r.marked = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic char_row_t marked_row(logic [7:0] c, logic last, out_item_t want);
        char_row_t r;
        r        = plain_row(c, last);
        r.marked = 1'b1;
        r.want   = want;
        return r;
    endfunction

    // Decode model: fills fresh[] with the results this character causes.
    task automatic decode_char(input in_item_t it);
        logic [6:0]  hv;
        logic [23:0] word;
        logic        closed;
        hv      = alphabet_lookup(it.in_char);
        closed  = 1'b0;
        fresh_n = 0;
        if (hv[6])
        begin
            if (group_pos == 2'd3)
            begin
                // Fourth sextet closes the group: three bytes, MSB first.
                word     = {held_sextets, hv[5:0]};
                fresh[0] = '{out_byte: word[23:16], byte_present: 1'b1,
                             end_of_message: 1'b0, too_short: 1'b0};
                fresh[1] = '{out_byte: word[15:8], byte_present: 1'b1,
                             end_of_message: 1'b0, too_short: 1'b0};
                fresh[2] = '{out_byte: word[7:0], byte_present: 1'b1,
                             end_of_message: it.last_char, too_short: 1'b0};
                fresh_n      = 3;
                closed       = 1'b1;
                had_group    = 1'b1;
                group_pos    = 2'd0;
                held_sextets = '0;
            end
            else
            begin
                held_sextets = {held_sextets[11:0], hv[5:0]};
                group_pos    = group_pos + 2'd1;
            end
        end
        if (it.last_char)
        begin
            // End without a closing group: partial group dropped, bare marker instead.
            if (!closed)
            begin
                fresh[0] = '{out_byte: 8'h00, byte_present: 1'b0,
                             end_of_message: 1'b1, too_short: !had_group};
                fresh_n  = 1;
            end
            group_pos    = 2'd0;
            held_sextets = '0;
            had_group    = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Random messages. Most are whole groups with random content and the odd
    // noise byte; the rest end inside a group or carry nothing but noise.
    task automatic build_random_messages();
        logic [7:0]  msg [$];
        int unsigned counted;
        int unsigned kind;
        int unsigned groups;
        int unsigned pads;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            msg.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise only: ends too short
                repeat ($urandom_range(1, 3)) msg.push_back(noise_char());
            end
            else if (kind == 1)
            begin
                // partial group only: ends too short
                repeat ($urandom_range(1, 3)) msg.push_back(alphabet_char($urandom_range(0, 64)));
            end
            else
            begin
                groups = $urandom_range(1, 4);
                for (int g = 0; g < groups; g++)
                begin
                    pads = (g == groups - 1) ? $urandom_range(0, 2) : 0;
                    for (int k = 0; k < 4; k++)
                    begin
                        if ($urandom_range(0, 9) == 0) msg.push_back(noise_char());
                        if (k >= 4 - pads) msg.push_back("=");
                        else msg.push_back(alphabet_char($urandom_range(0, 63)));
                    end
                end
                case ($urandom_range(0, 9))
                    0, 1:    repeat ($urandom_range(1, 3))
                                 msg.push_back(alphabet_char($urandom_range(0, 64)));
                    2:       msg.push_back(noise_char());
                    default: ;
                endcase
            end
            for (int i = 0; i < msg.size(); i++)
            begin
                char_rows.push_back(plain_row(msg[i], i == msg.size() - 1));
                counted++;
            end
        end
    endtask

    task automatic send_chars();
        int unsigned gap;
        for (int i = 0; i < char_rows.size(); i++)
        begin
            // every fourth stretch of 24 characters runs with no idling at all
            steady = ((i / 24) % 4) == 3;
            gap    = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                char_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            char_if.valid   <= 1'b1;
            char_if.payload <= char_rows[i].item;
            @(posedge clk);
            while (!char_if.ready) @(posedge clk);
            @(negedge clk);
        end
        char_if.valid <= 1'b0;
    endtask

    // Scoreboard: results are checked before the same-edge character is modeled,
    // since a result can only belong to a character taken earlier.
    always @(posedge clk)
    begin : scoreboard
        out_item_t got;
        out_item_t want;
        char_row_t row;
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                got = byte_if.payload;
                if (pending_bytes.size() == 0)
                    report_mismatch("result with nothing expected", 32'(got), 32'd0);
                else
                begin
                    want = pending_bytes.pop_front();
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
                    if (got.byte_present != want.byte_present)
                        report_mismatch("byte_present", 32'(got.byte_present),
                                        32'(want.byte_present));
                    if (got.end_of_message != want.end_of_message)
                        report_mismatch("end_of_message", 32'(got.end_of_message),
                                        32'(want.end_of_message));
                    if (got.too_short != want.too_short)
                        report_mismatch("too_short", 32'(got.too_short),
                                        32'(want.too_short));
                end
            end
            if (char_if.valid && char_if.ready)
            begin
                row = char_rows[chars_taken];
                chars_taken++;
                decode_char(row.item);
                // marked rows still run the model so its state stays in step
                if (row.marked) pending_bytes.push_back(row.want);
                else
                    for (int k = 0; k < fresh_n; k++) pending_bytes.push_back(fresh[k]);
            end
        end
    end

    // Watchdog: any transaction on either side resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_if.valid && char_if.ready) || (byte_if.valid && byte_if.ready))
                stalled_cycles = 0;
            else
            begin
                stalled_cycles++;
                if (stalled_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("** base64_stream_decoder: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Receiver: stalls a random number of cycles before each result.
    initial
    begin : receiver
        int unsigned stall;
        byte_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                byte_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            byte_if.ready <= 1'b1;
            @(posedge clk);
            while (!byte_if.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        char_if.valid   = 1'b0;
        char_if.payload = '0;
        chars_taken     = 0;
        errors          = 0;
        stalled_cycles  = 0;
        steady          = 1'b0;
        group_pos       = '0;
        held_sextets    = '0;
        had_group       = 1'b0;

        // Directed messages:
        //  - lone character right after reset: too short
        //  - lone non-alphabet byte 00 as the last: dropped, still too short
        //  - "////" with byte FF dropped inside, closed by the last: FF FF FF, end on third
        //  - "+9z=" then "Q=" as last: group, then partial dropped, bare end marker
        //  - "AZa0" then "=" and byte 80 as last: non-alphabet last after a group
        //  - "====" closed by the last: three zero bytes
        directed_rows = '{
            marked_row("A", 1'b1, END_TOO_SHORT),
            marked_row(8'h00, 1'b1, END_TOO_SHORT),
            plain_row("/", 1'b0), plain_row("/", 1'b0), plain_row(8'hFF, 1'b0),
            plain_row("/", 1'b0), plain_row("/", 1'b1),
            plain_row("+", 1'b0), plain_row("9", 1'b0), plain_row("z", 1'b0),
            plain_row("=", 1'b0), plain_row("Q", 1'b0),
            marked_row("=", 1'b1, END_AFTER_GROUP),
            plain_row("A", 1'b0), plain_row("Z", 1'b0), plain_row("a", 1'b0),
            plain_row("0", 1'b0), plain_row("=", 1'b0),
            marked_row(8'h80, 1'b1, END_AFTER_GROUP),
            plain_row("=", 1'b0), plain_row("=", 1'b0), plain_row("=", 1'b0),
            plain_row("=", 1'b1)
        };
        for (int i = 0; i < DIRECTED_N; i++) char_rows.push_back(directed_rows[i]);
        build_random_messages();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_chars();

        // everything is sent; wait out the owed results, then a short quiet spell
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("** base64_stream_decoder: PASSED **");
        else
            $display("** base64_stream_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
